@@ rtl/tlv_stream_parser_core_macros.svh @@
// Assertion macros shared by the parser checker.
`ifndef TLV_STREAM_PARSER_CORE_MACROS_SVH
`define TLV_STREAM_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TSP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlv stream parser: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define TSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlv stream parser: next-cycle check failed");

`endif

@@ rtl/tlvsp_pkg.sv @@
// Types and constants shared by the parser modules.
`timescale 1ns / 1ps
package tlvsp_pkg;

  // Record type codes carried in the header.
  localparam logic [7:0] REC_INT    = 8'h01;
  localparam logic [7:0] REC_BOOL   = 8'h02;
  localparam logic [7:0] REC_STRING = 8'h04;
  localparam logic [7:0] REC_ARRAY  = 8'h05;

  // Result kinds.
  localparam logic [2:0] KIND_BOOL      = 3'd0;
  localparam logic [2:0] KIND_INT       = 3'd1;
  localparam logic [2:0] KIND_STR_BYTE  = 3'd2;
  localparam logic [2:0] KIND_STR_EMPTY = 3'd3;
  localparam logic [2:0] KIND_ELEMENT   = 3'd4;
  localparam logic [2:0] KIND_TRUNC     = 3'd5;
  localparam logic [2:0] KIND_INNER_TRC = 3'd6;
  localparam logic [2:0] KIND_END       = 3'd7;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_BOOL_KEY   = 3'd0;
  localparam logic [2:0] REG_INT_KEY    = 3'd1;
  localparam logic [2:0] REG_STRING_KEY = 3'd2;
  localparam logic [2:0] REG_ARRAY_KEY  = 3'd3;
  localparam logic [2:0] REG_ELEM_TAG   = 3'd4;

  localparam int ADDR_W   = 5;
  localparam int QUEUE_D  = 4;
  localparam int QPTR_W   = $clog2(QUEUE_D);

  typedef struct packed {
    logic [15:0] bool_key_tag;
    logic [15:0] int_key_tag;
    logic [15:0] string_key_tag;
    logic [15:0] array_key_tag;
    logic [15:0] element_tag;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] value;
    logic        slast;
    logic        done;
  } result_t;

endpackage

@@ rtl/tlv_stream_parser_core.sv @@
// Top level of the streaming tag/type/length/value parser.
// The result of a byte is written into the result queue as the byte is taken.
// Throughput: one byte per cycle unless full, which rises only when four results are queued.
// Each byte gives at most one result, so the queue drains as fast as pop allows.
// Reset (synchronous, rst high) clears the parse state and the queue and reloads the tags.
`timescale 1ns / 1ps
module tlv_stream_parser_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [7:0]                   data_byte,
  input  logic                         buffer_end,
  output logic                         empty,
  input  logic                         pop,
  output logic [2:0]                   record_kind,
  output logic signed [63:0]           record_value,
  output logic                         string_last,
  output logic                         buffer_done,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tlvsp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import tlvsp_pkg::*;

  cfg_t    cfg;
  result_t front_res;
  result_t head;
  logic    front_valid;
  logic    accept;

  assign accept = push && !full;

  tlvsp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tlvsp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (data_byte),
    .buffer_end (buffer_end),
    .cfg        (cfg),
    .res_valid  (front_valid),
    .res        (front_res)
  );

  tlvsp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && front_valid),
    .wr_data (front_res),
    .rd_en   (pop),
    .rd_data (head),
    .empty   (empty),
    .full    (full)
  );

  assign record_kind  = head.kind;
  assign record_value = $signed(head.value);
  assign string_last  = head.slast;
  assign buffer_done  = head.done;

endmodule

@@ rtl/tlvsp_cfg.sv @@
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
module tlvsp_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [tlvsp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output tlvsp_pkg::cfg_t           cfg
);
  import tlvsp_pkg::*;

  logic [2:0] reg_index;
  logic       wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign wr_en     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bool_key_tag   <= 16'd1;
      cfg.int_key_tag    <= 16'd2;
      cfg.string_key_tag <= 16'd3;
      cfg.array_key_tag  <= 16'd4;
      cfg.element_tag    <= 16'd1;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_BOOL_KEY:   cfg.bool_key_tag   <= pwdata[15:0];
        REG_INT_KEY:    cfg.int_key_tag    <= pwdata[15:0];
        REG_STRING_KEY: cfg.string_key_tag <= pwdata[15:0];
        REG_ARRAY_KEY:  cfg.array_key_tag  <= pwdata[15:0];
        REG_ELEM_TAG:   cfg.element_tag    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_BOOL_KEY:   prdata = {16'd0, cfg.bool_key_tag};
      REG_INT_KEY:    prdata = {16'd0, cfg.int_key_tag};
      REG_STRING_KEY: prdata = {16'd0, cfg.string_key_tag};
      REG_ARRAY_KEY:  prdata = {16'd0, cfg.array_key_tag};
      REG_ELEM_TAG:   prdata = {16'd0, cfg.element_tag};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

@@ rtl/tlvsp_front.sv @@
// Front end: takes one byte per cycle while accept is high, tracks the record structure and classifies results.
`timescale 1ns / 1ps
module tlvsp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                buffer_end,
  input  tlvsp_pkg::cfg_t     cfg,
  output logic                res_valid,
  output tlvsp_pkg::result_t  res
);
  import tlvsp_pkg::*;

  localparam logic [1:0] PH_HDR  = 2'd0;
  localparam logic [1:0] PH_VAL  = 2'd1;
  localparam logic [1:0] PH_AHDR = 2'd2;
  localparam logic [1:0] PH_AVAL = 2'd3;

  localparam logic [2:0] CL_SKIP = 3'd0;
  localparam logic [2:0] CL_BOOL = 3'd1;
  localparam logic [2:0] CL_INT  = 3'd2;
  localparam logic [2:0] CL_STR  = 3'd3;
  localparam logic [2:0] CL_ELEM = 3'd5;

  logic [1:0]  phase, phase_next;
  logic [55:0] header_shift, header_shift_next;
  logic [2:0]  header_count, header_count_next;
  logic [31:0] value_remaining, value_remaining_next;
  logic [31:0] array_remaining, array_remaining_next;
  logic [63:0] value_acc, value_acc_next;
  logic [2:0]  entry_class, entry_class_next;

  logic [55:0] hs_new;
  logic [63:0] acc_new;
  logic [15:0] hdr_tag;
  logic [7:0]  hdr_type;
  logic [31:0] hdr_len;
  logic        inner;
  logic        vr_done;
  logic        ar_one;

  assign hs_new   = {header_shift[47:0], data_byte};
  assign acc_new  = {value_acc[55:0], data_byte};
  assign hdr_tag  = hs_new[55:40];
  assign hdr_type = hs_new[39:32];
  assign hdr_len  = hs_new[31:0];
  assign inner    = (phase == PH_AHDR);
  assign vr_done  = (value_remaining == 32'd1);
  assign ar_one   = (array_remaining == 32'd1);

  always_comb begin
    phase_next           = phase;
    header_shift_next    = header_shift;
    header_count_next    = header_count;
    value_remaining_next = value_remaining;
    array_remaining_next = array_remaining;
    value_acc_next       = value_acc;
    entry_class_next     = entry_class;
    res_valid            = 1'b0;
    res.kind             = KIND_END;
    res.value            = 64'd0;
    res.slast            = 1'b0;
    res.done             = buffer_end;

    unique case (phase) inside
      PH_HDR, PH_AHDR: begin
        if (inner) begin
          array_remaining_next = array_remaining - 32'd1;
        end
        header_shift_next = hs_new;
        header_count_next = header_count + 3'd1;
        if (header_count == 3'd6) begin
          header_count_next = 3'd0;
          value_acc_next    = 64'd0;
          if (!inner) begin
            if (hdr_tag == cfg.array_key_tag && hdr_type == REC_ARRAY) begin
              if (hdr_len != 32'd0) begin
                phase_next           = PH_AHDR;
                array_remaining_next = hdr_len;
              end
            end else if (hdr_tag == cfg.string_key_tag && hdr_type == REC_STRING &&
                         hdr_len == 32'd0) begin
              res_valid = 1'b1;
              res.kind  = KIND_STR_EMPTY;
            end else if (hdr_len != 32'd0) begin
              if (hdr_tag == cfg.bool_key_tag && hdr_type == REC_BOOL && hdr_len == 32'd1) begin
                entry_class_next = CL_BOOL;
              end else if (hdr_tag == cfg.int_key_tag && hdr_type == REC_INT &&
                           hdr_len == 32'd8) begin
                entry_class_next = CL_INT;
              end else if (hdr_tag == cfg.string_key_tag && hdr_type == REC_STRING) begin
                entry_class_next = CL_STR;
              end else begin
                entry_class_next = CL_SKIP;
              end
              value_remaining_next = hdr_len;
              phase_next           = PH_VAL;
            end
          end else if (hdr_len >= array_remaining) begin
            // The inner record overruns what is left of the array; skip the rest of it.
            res_valid = 1'b1;
            res.kind  = KIND_INNER_TRC;
            if (!ar_one) begin
              value_remaining_next = array_remaining - 32'd1;
              entry_class_next     = CL_SKIP;
              phase_next           = PH_VAL;
            end else begin
              phase_next = PH_HDR;
            end
            array_remaining_next = 32'd0;
          end else if (hdr_len == 32'd0) begin
            if (ar_one) begin
              phase_next = PH_HDR;
            end
          end else begin
            // Remaining array bytes after this header and its value: ar - 1 - len.
            array_remaining_next = array_remaining + ~hdr_len;
            value_remaining_next = hdr_len;
            entry_class_next     = (hdr_tag == cfg.element_tag && hdr_type == REC_INT &&
                                    hdr_len == 32'd8) ? CL_ELEM : CL_SKIP;
            phase_next           = PH_AVAL;
          end
        end else if (inner && ar_one) begin
          header_count_next = 3'd0;
          phase_next        = PH_HDR;
        end
      end
      PH_VAL: begin
        value_remaining_next = value_remaining - 32'd1;
        value_acc_next       = acc_new;
        case (entry_class)
          CL_BOOL: begin
            res_valid = 1'b1;
            res.kind  = KIND_BOOL;
            res.value = {63'd0, (data_byte != 8'd0)};
          end
          CL_INT: begin
            if (vr_done) begin
              res_valid = 1'b1;
              res.kind  = KIND_INT;
              res.value = acc_new;
            end
          end
          CL_STR: begin
            res_valid = 1'b1;
            res.kind  = KIND_STR_BYTE;
            res.value = {56'd0, data_byte};
            res.slast = vr_done;
          end
          default: ;
        endcase
        if (vr_done) begin
          phase_next       = PH_HDR;
          entry_class_next = CL_SKIP;
        end
      end
      default: begin
        value_remaining_next = value_remaining - 32'd1;
        value_acc_next       = acc_new;
        if (vr_done) begin
          if (entry_class == CL_ELEM) begin
            res_valid = 1'b1;
            res.kind  = KIND_ELEMENT;
            res.value = acc_new;
          end
          entry_class_next  = CL_SKIP;
          header_count_next = 3'd0;
          phase_next        = (array_remaining != 32'd0) ? PH_AHDR : PH_HDR;
        end
      end
    endcase

    if (buffer_end) begin
      // Any phase other than the outer header still owes bytes of an outer record.
      if (phase_next != PH_HDR) begin
        res_valid = 1'b1;
        res.kind  = KIND_TRUNC;
        res.value = 64'd0;
        res.slast = 1'b0;
      end else if (!res_valid) begin
        res_valid = 1'b1;
        res.kind  = KIND_END;
      end
      phase_next           = PH_HDR;
      header_shift_next    = 56'd0;
      header_count_next    = 3'd0;
      value_remaining_next = 32'd0;
      array_remaining_next = 32'd0;
      value_acc_next       = 64'd0;
      entry_class_next     = CL_SKIP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HDR;
      header_shift    <= 56'd0;
      header_count    <= 3'd0;
      value_remaining <= 32'd0;
      array_remaining <= 32'd0;
      value_acc       <= 64'd0;
      entry_class     <= CL_SKIP;
    end else if (accept) begin
      phase           <= phase_next;
      header_shift    <= header_shift_next;
      header_count    <= header_count_next;
      value_remaining <= value_remaining_next;
      array_remaining <= array_remaining_next;
      value_acc       <= value_acc_next;
      entry_class     <= entry_class_next;
    end
  end

endmodule

@@ rtl/tlvsp_queue.sv @@
// Result queue between the front end and the output side.
`timescale 1ns / 1ps
module tlvsp_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  tlvsp_pkg::result_t wr_data,
  input  logic               rd_en,
  output tlvsp_pkg::result_t rd_data,
  output logic               empty,
  output logic               full
);
  import tlvsp_pkg::*;

  result_t            mem [QUEUE_D];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;
  logic               do_wr;
  logic               do_rd;

  assign empty   = (count == '0);
  assign full    = (count == (QPTR_W + 1)'(QUEUE_D));
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

endmodule

@@ rtl/tlvsp_checker.sv @@
// Port-level checks on the parser core, bound to the top level.
`timescale 1ns / 1ps
`include "tlv_stream_parser_core_macros.svh"
module tlvsp_checker (
  input logic               clk,
  input logic               rst,
  input logic               empty,
  input logic               pop,
  input logic [2:0]         record_kind,
  input logic signed [63:0] record_value,
  input logic               string_last
);
  import tlvsp_pkg::*;

  logic zero_value_kind;

  // Kinds whose value is always reported as zero.
  assign zero_value_kind = (record_kind == KIND_STR_EMPTY) || (record_kind == KIND_TRUNC) ||
                           (record_kind == KIND_INNER_TRC) || (record_kind == KIND_END);

  `TSP_ASSERT_NOW(a_empty_after_reset, clk, rst, $past(rst), empty)
  `TSP_ASSERT_NOW(a_zero_value_kinds, clk, rst, !empty && zero_value_kind, record_value == 64'sd0)
  `TSP_ASSERT_NOW(a_last_only_on_string, clk, rst, !empty && string_last, record_kind == KIND_STR_BYTE)
  `TSP_ASSERT_NOW(a_bool_is_bit, clk, rst, !empty && record_kind == KIND_BOOL, record_value == 64'sd0 || record_value == 64'sd1)
  `TSP_ASSERT_NEXT(a_head_holds, clk, rst, !empty && !pop, !empty && $stable(record_kind) && $stable(record_value))

endmodule

bind tlv_stream_parser_core tlvsp_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .empty        (empty),
  .pop          (pop),
  .record_kind  (record_kind),
  .record_value (record_value),
  .string_last  (string_last)
);
